>>> rtl/core/mwsf_pkg.sv
package mwsf_pkg;

    localparam int VALUE_W   = 16;
    localparam int POS_W     = 16;
    localparam int OUT_SUM_W = 24;
    localparam int CFG_W     = 9;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_W-1:0] WINDOW_LEN_RST = CFG_W'(10);

    // what the sum stage hands to the compare stage beside the sum itself
    typedef struct packed {
        logic             vld;
        logic             full;
        logic             last;
        logic [POS_W-1:0] start;
    } t_s1_info;

endpackage

>>> rtl/core/mwsf_cell.sv
module mwsf_cell
    import mwsf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_shift,
    input  logic               i_insert,
    input  logic [VALUE_W-1:0] i_new_value,
    input  logic [VALUE_W-1:0] i_next_value,
    output logic [VALUE_W-1:0] o_value
);

    logic [VALUE_W-1:0] r_value;

    // the cell at the window tap takes the new sample, all others take from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_insert ? i_new_value : i_next_value;
        end
    end

    assign o_value = r_value;

endmodule

>>> rtl/core/mwsf_best.sv
module mwsf_best
    import mwsf_pkg::*;
#(
    parameter int SUM_W = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_s1_info              i_info,
    input  logic signed [SUM_W-1:0] i_sum,
    input  logic                  i_res_ready,
    output logic                  o_stall,
    output logic                  o_res_valid,
    output logic [OUT_DATA_W-1:0] o_res_data,
    output logic                  o_res_found
);

    localparam int WIDE_W = (SUM_W > OUT_SUM_W) ? SUM_W : OUT_SUM_W;
    localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'((64'sd1 <<< (OUT_SUM_W - 1)) - 1);
    localparam logic signed [WIDE_W-1:0] SAT_LO = WIDE_W'(-(64'sd1 <<< (OUT_SUM_W - 1)));

    logic signed [SUM_W-1:0]     r_best_sum;
    logic signed [SUM_W-1:0]     n_best_sum;
    logic [POS_W-1:0]            r_best_start;
    logic [POS_W-1:0]            n_best_start;
    logic                        r_have;
    logic                        n_have;
    logic                        r_res_valid;
    logic                        n_res_valid;
    logic [OUT_DATA_W-1:0]       r_res_data;
    logic [OUT_DATA_W-1:0]       n_res_data;
    logic                        r_res_found;
    logic                        n_res_found;
    logic                        upd;
    logic                        step;
    logic signed [SUM_W-1:0]     cand_sum;
    logic [POS_W-1:0]            cand_start;
    logic                        cand_have;
    logic signed [WIDE_W-1:0]    wide_sum;
    logic [OUT_SUM_W-1:0]        sat_sum;

    // a last item may not leave while the previous result still waits
    assign o_stall = i_info.vld && i_info.last && r_res_valid && !i_res_ready;
    assign step    = i_info.vld && !o_stall;
    // strict compare keeps the earliest window on a tie
    assign upd     = i_info.full && (!r_have || (i_sum < r_best_sum));

    assign cand_sum   = upd ? i_sum : r_best_sum;
    assign cand_start = upd ? i_info.start : r_best_start;
    assign cand_have  = upd || r_have;

    always_comb begin
        wide_sum = WIDE_W'(cand_sum);
        if (wide_sum > SAT_HI) begin
            sat_sum = OUT_SUM_W'(SAT_HI);
        end else if (wide_sum < SAT_LO) begin
            sat_sum = OUT_SUM_W'(SAT_LO);
        end else begin
            sat_sum = OUT_SUM_W'(wide_sum);
        end
    end

    always_comb begin
        n_best_sum   = r_best_sum;
        n_best_start = r_best_start;
        n_have       = r_have;
        n_res_valid  = r_res_valid && !i_res_ready;
        n_res_data   = r_res_data;
        n_res_found  = r_res_found;
        if (step) begin
            if (i_info.last) begin
                n_res_valid  = 1'b1;
                n_res_found  = cand_have;
                n_res_data   = cand_have ? {sat_sum, cand_start} : '0;
                n_best_sum   = '0;
                n_best_start = '0;
                n_have       = 1'b0;
            end else begin
                n_best_sum   = cand_sum;
                n_best_start = cand_start;
                n_have       = cand_have;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_have      <= n_have;
            r_res_valid <= n_res_valid;
        end
        r_best_sum   <= n_best_sum;
        r_best_start <= n_best_start;
        r_res_data   <= n_res_data;
        r_res_found  <= n_res_found;
    end

    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res_data;
    assign o_res_found = r_res_found;

endmodule

>>> rtl/core/min_window_sum_finder.sv
// Minimum-sum sliding window finder. Samples stream in one per transfer on s_axis, with
// tlast on the final sample of a list; on that sample one result leaves on m_axis: the
// start index and saturated sum of the first window of window_len samples with the
// smallest sum, and tuser set if any full window existed (position and sum read zero
// otherwise). The user must write the window length on the cfg channel only while the
// block is idle; the block does not enforce this. It is taken up at the first sample of
// the next list; 0 acts as 1 and values above WINDOW_MAX act as WINDOW_MAX. The block
// takes one sample every clock cycle unless stalled. The delay line is a row of WINDOW_MAX
// cells in which the new sample is written at the cell of the current window length and
// the oldest sample falls out of cell 0, so there is no read address and no clearing pass.
// Input ready drops only while a result waits on m_axis and the next tlast sample has
// reached the compare stage. After LIST_MAX samples further values of a list are ignored.
module min_window_sum_finder
    import mwsf_pkg::*;
#(
    parameter int WINDOW_MAX = 256,
    parameter int LIST_MAX   = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data,     // window_len
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] value
    input  logic                  s_axis_tlast,   // last_item
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] position, [39:16] min_sum
    output logic                  m_axis_tuser    // found
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int CNT_W = $clog2(LIST_MAX + 1);
    localparam int SUM_W = VALUE_W + $clog2(WINDOW_MAX);

    logic [CFG_W-1:0]         r_window_len;
    logic [LEN_W-1:0]         r_active_len;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;
    t_s1_info                 r_s1;
    logic signed [SUM_W-1:0]  r_s1_sum;

    logic                     s_fire;
    logic                     stall;
    logic                     first;
    logic                     in_range;
    logic [LEN_W-1:0]         eff_len;
    logic [LEN_W-1:0]         len_use;
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] old_value;
    logic                     full;
    logic [POS_W-1:0]         start;
    logic [VALUE_W-1:0]       cell_val [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]    insert;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !stall;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign value         = s_axis_tdata[VALUE_W-1:0];
    assign first         = (r_count == '0);
    assign in_range      = 32'(r_count) < LIST_MAX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_len <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_window_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(r_window_len) > WINDOW_MAX) begin
            eff_len = LEN_W'(WINDOW_MAX);
        end else begin
            eff_len = LEN_W'(r_window_len);
        end
    end

    assign len_use = first ? eff_len : r_active_len;

    // delay line
    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        logic [VALUE_W-1:0] next_value;
        assign insert[k] = (len_use == LEN_W'(k + 1));
        if (k == WINDOW_MAX - 1) begin : g_end
            assign next_value = '0;
        end else begin : g_mid
            assign next_value = cell_val[k+1];
        end
        mwsf_cell u_cell (
            .i_clk        (i_clk),
            .i_shift      (s_fire && in_range),
            .i_insert     (insert[k]),
            .i_new_value  (value),
            .i_next_value (next_value),
            .o_value      (cell_val[k])
        );
    end

    // cell 0 holds the sample that leaves the window once the window has filled
    assign old_value = (32'(r_count) >= 32'(len_use)) ? cell_val[0] : '0;

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        if (in_range) begin
            n_count = r_count + CNT_W'(1);
            n_sum   = r_sum + SUM_W'(value) - SUM_W'(old_value);
        end
        full  = in_range && (32'(n_count) >= 32'(len_use));
        start = POS_W'(32'(n_count) - 32'(len_use));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_s1    <= '0;
        end else begin
            if (s_fire) begin
                r_count <= s_axis_tlast ? '0 : n_count;
                r_sum   <= s_axis_tlast ? '0 : n_sum;
            end
            if (!stall) begin
                r_s1.vld <= s_fire;
            end
            if (s_fire) begin
                r_s1.full  <= full;
                r_s1.last  <= s_axis_tlast;
                r_s1.start <= start;
            end
        end
        if (s_fire) begin
            r_s1_sum <= n_sum;
        end
        if (s_fire && first) begin
            r_active_len <= eff_len;
        end
    end

    mwsf_best #(
        .SUM_W (SUM_W)
    ) u_best (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_info      (r_s1),
        .i_sum       (r_s1_sum),
        .i_res_ready (m_axis_tready),
        .o_stall     (stall),
        .o_res_valid (m_axis_tvalid),
        .o_res_data  (m_axis_tdata),
        .o_res_found (m_axis_tuser)
    );

endmodule

>>> rtl/core/mwsf_checker.sv
module mwsf_checker
    import mwsf_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no full window means position and sum read zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("result without window carries data");

    // a fresh result follows an earlier tlast transfer
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("result without a last transfer");

    // input backpressure only comes from a stalled result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule

bind min_window_sum_finder mwsf_checker u_mwsf_checker (.*);

>>> tb/sv/min_window_sum_checker.sv
`timescale 1ns / 100ps

module min_window_sum_checker
    import mwsf_pkg::*;
#(
    parameter int WINDOW_MAX = 256,
    parameter int LIST_MAX   = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_in_last,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [OUT_DATA_W-1:0] i_out_data,
    input  logic                  i_out_found,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic [POS_W-1:0]            pos;
        logic signed [OUT_SUM_W-1:0] sum;
        logic                        found;
    } t_min_result;

    t_min_result               min_results_q[$];

    // predictor state
    logic [CFG_W-1:0]          len_reg;
    int unsigned               list_len_lat;
    logic signed [VALUE_W-1:0] tap_line[WINDOW_MAX];
    longint                    win_acc;
    int unsigned               sample_idx;
    longint                    min_acc;
    int unsigned               min_pos;
    logic                      min_seen;
    int                        err_cnt;

    task automatic clear_search();
        win_acc    = 0;
        sample_idx = 0;
        min_acc    = 0;
        min_pos    = 0;
        min_seen   = 1'b0;
    endtask

    task automatic step_window(input logic signed [VALUE_W-1:0] v, input logic last);
        int unsigned               eff;
        logic signed [VALUE_W-1:0] oldest;
        longint                    sat;
        t_min_result               r;
        if (sample_idx == 0) begin
            eff = (len_reg == 0) ? 1 : int'(len_reg);
            if (eff > WINDOW_MAX)
                eff = WINDOW_MAX;
            list_len_lat = eff;
        end
        if (sample_idx < LIST_MAX) begin
            oldest = '0;
            if (sample_idx >= list_len_lat)
                oldest = tap_line[(sample_idx - list_len_lat) % WINDOW_MAX];
            tap_line[sample_idx % WINDOW_MAX] = v;
            win_acc = win_acc + longint'(v) - longint'(oldest);
            sample_idx++;
            // strictly smaller only, so the earliest window keeps a tie
            if (sample_idx >= list_len_lat && (!min_seen || win_acc < min_acc)) begin
                min_acc  = win_acc;
                min_pos  = sample_idx - list_len_lat;
                min_seen = 1'b1;
            end
        end
        if (last) begin
            r = '0;
            if (min_seen) begin
                sat = min_acc;
                if (sat > 64'sd8388607)
                    sat = 64'sd8388607;
                if (sat < -64'sd8388608)
                    sat = -64'sd8388608;
                r.pos   = POS_W'(min_pos);
                r.sum   = OUT_SUM_W'(sat);
                r.found = 1'b1;
            end
            min_results_q.push_back(r);
            clear_search();
        end
    endtask

    task automatic check_result();
        t_min_result exp_r;
        t_min_result act_r;
        act_r.pos   = i_out_data[POS_W-1:0];
        act_r.sum   = i_out_data[POS_W +: OUT_SUM_W];
        act_r.found = i_out_found;
        if (min_results_q.size() == 0) begin
            $display("%0t: result with nothing expected: position %0d sum %0d found %0b",
                     $time, act_r.pos, act_r.sum, act_r.found);
            err_cnt++;
        end else begin
            exp_r = min_results_q.pop_front();
            if (act_r.pos !== exp_r.pos) begin
                $display("%0t: position mismatch: expected %0d actual %0d",
                         $time, exp_r.pos, act_r.pos);
                err_cnt++;
            end
            if (act_r.sum !== exp_r.sum) begin
                $display("%0t: min_sum mismatch: expected %0d actual %0d",
                         $time, exp_r.sum, act_r.sum);
                err_cnt++;
            end
            if (act_r.found !== exp_r.found) begin
                $display("%0t: found mismatch: expected %0b actual %0b",
                         $time, exp_r.found, act_r.found);
                err_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            len_reg      <= WINDOW_LEN_RST;
            list_len_lat = WINDOW_LEN_RST;
            clear_search();
            min_results_q.delete();
        end else begin
            // compare before predicting so a result never meets its own item
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_in_valid && i_in_ready)
                step_window(i_in_data[VALUE_W-1:0], i_in_last);
            if (i_cfg_valid && i_cfg_ready)
                len_reg <= i_cfg_data;
        end
        o_errors  <= err_cnt;
        o_pending <= min_results_q.size();
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mwsf_pkg::*;

    localparam int WIN_DEPTH  = 256;
    localparam int LIST_CAP   = 65536;
    localparam int RAND_ITEMS = 300;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  calm          = 1'b0;
    int                    errors;
    int                    pending;
    int                    rand_sent;

    min_window_sum_finder #(
        .WINDOW_MAX (WIN_DEPTH),
        .LIST_MAX   (LIST_CAP)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    min_window_sum_checker #(
        .WINDOW_MAX (WIN_DEPTH),
        .LIST_MAX   (LIST_CAP)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_found (m_axis_tuser),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #100_000;
        $display("[min_window_sum_finder] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 8);
        end
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: pick_value = 16'h8000;
            1: pick_value = 16'h7fff;
            2, 3: pick_value = VALUE_W'($urandom);
            // narrow values make equal sums, so ties get exercised
            default: pick_value = VALUE_W'(int'($urandom_range(0, 16)) - 8);
        endcase
    endfunction

    task automatic send_sample(input logic [VALUE_W-1:0] v, input logic last);
        while (!calm && $urandom_range(0, 99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic send_list(input int n, input logic close);
        for (int i = 0; i < n; i++)
            send_sample(pick_value(), close && (i == n - 1));
    endtask

    task automatic send_fill(input int n, input logic [VALUE_W-1:0] v);
        for (int i = 0; i < n; i++)
            send_sample(v, i == n - 1);
    endtask

    // waits out all results and the pipeline, then writes the window length
    task automatic set_window(input logic [CFG_W-1:0] len);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_window();
        logic [CFG_W-1:0] big[9] = '{0, 64, 128, 200, 255, 256, 257, 300, 511};
        if ($urandom_range(0, 5) == 0)
            pick_window = big[$urandom_range(0, 8)];
        else
            pick_window = CFG_W'($urandom_range(1, 16));
    endfunction

    initial begin
        logic [CFG_W-1:0] len;
        int               eff;
        int               n;
        int               phase;

        rand_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default length of 10: no full window, exactly one window, all ties
        send_sample(16'h8000, 1'b1);
        send_list(9, 1'b1);
        send_list(10, 1'b1);
        send_fill(14, 16'h0000);

        // zero length acts as one, earliest of equal minima wins
        set_window(0);
        send_sample(16'd5, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b1);
        set_window(1);
        send_sample(16'h7fff, 1'b1);
        set_window(2);
        send_sample(16'd3, 1'b0);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'd3, 1'b1);

        // oversized length saturates; most negative sum of a full window
        set_window(511);
        send_fill(256, 16'h8000);
        set_window(256);
        send_list(40, 1'b1);

        // length written mid-list only applies to the following list
        set_window(3);
        send_list(4, 1'b0);
        set_window(2);
        send_list(3, 1'b1);
        send_list(5, 1'b1);

        phase = 0;
        while (rand_sent < RAND_ITEMS) begin
            len = pick_window();
            calm <= (phase == 2);
            set_window(len);
            eff = (len == 0) ? 1 : ((len > WIN_DEPTH) ? WIN_DEPTH : int'(len));
            repeat ($urandom_range(3, 6)) begin
                if (eff > 16)
                    n = ($urandom_range(0, 3) == 0) ? eff + $urandom_range(0, 6)
                                                    : $urandom_range(1, 40);
                else
                    n = $urandom_range(1, eff + 20);
                send_list(n, 1'b1);
                rand_sent += n;
            end
            // sometimes leave a list open across the next length write
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 5);
                send_list(n, 1'b0);
                rand_sent += n;
            end
            phase++;
        end
        calm <= 1'b0;

        // closes any list still open
        set_window(256);
        send_list(12, 1'b1);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[min_window_sum_finder] OK");
        end else begin
            $display("[min_window_sum_finder] ERROR");
        end
        $finish;
    end

endmodule

>>> min_window_sum_finder.f
rtl/core/mwsf_pkg.sv
rtl/core/mwsf_cell.sv
rtl/core/mwsf_best.sv
rtl/core/min_window_sum_finder.sv
rtl/core/mwsf_checker.sv
tb/sv/min_window_sum_checker.sv
tb/sv/tb_top.sv
